/* hw/rtl/dfir_pkg.sv */
// shared types and constants of the decimating fir resampler
// holds the state type, the mac control struct and the q1.17 coefficient rom
// no dependencies
package dfir_pkg;

   localparam int COEF_W      = 18;
   localparam int ROM_LEN     = 31;
   localparam int ROM_ADDR_W  = 5;
   localparam int TAP_IDX_W   = 7;
   localparam int ROUND_SHIFT = 17;
   localparam int ROUND_BIAS  = 65536;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic                 clear;
      logic                 valid;
      logic                 use_x;
      logic [TAP_IDX_W-1:0] tap;
   } mac_ctl_type;

   // hamming-windowed sinc, cutoff 1/3, unit sum
   localparam logic signed [COEF_W-1:0] COEF_ROM [ROM_LEN] = '{
      18'sd0,      18'sd232,    18'sd332,    18'sd0,
      -18'sd761,   -18'sd1118,  18'sd0,      18'sd2217,
      18'sd3029,   18'sd0,      -18'sd5552,  -18'sd7642,
      18'sd0,      18'sd17310,  18'sd35691,  18'sd43596,
      18'sd35691,  18'sd17310,  18'sd0,      -18'sd7642,
      -18'sd5552,  18'sd0,      18'sd3029,   18'sd2217,
      18'sd0,      -18'sd1118,  -18'sd761,   18'sd0,
      18'sd332,    18'sd232,    18'sd0
   };

   // taps past the rom read as zero
   function automatic logic signed [COEF_W-1:0] coef_at(input logic [TAP_IDX_W-1:0] idx);
      logic signed [COEF_W-1:0] val;
      if (idx < TAP_IDX_W'(ROM_LEN)) begin
         val = COEF_ROM[idx[ROM_ADDR_W-1:0]];
      end else begin
         val = '0;
      end
      return val;
   endfunction

endpackage

/* hw/rtl/dfir_mac.sv */
// shared multiply-accumulate unit with round and saturate to the sample width
// depends on dfir_pkg for the coefficient rom and the mac control struct
module dfir_mac #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  dfir_pkg::mac_ctl_type          ctl,
   input  logic signed [SAMPLE_BITS-1:0]  hist_data,
   input  logic signed [SAMPLE_BITS-1:0]  x_sample,
   output logic                           done,
   output logic signed [SAMPLE_BITS-1:0]  result
);

   localparam int PROD_W = SAMPLE_BITS + dfir_pkg::COEF_W;
   localparam int ACC_W  = PROD_W + dfir_pkg::TAP_IDX_W;
   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((2 ** (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-(2 ** (SAMPLE_BITS - 1)));

   logic signed [SAMPLE_BITS-1:0]     operand;
   logic signed [dfir_pkg::COEF_W-1:0] coef;
   logic signed [PROD_W-1:0]          prod_in;
   logic signed [PROD_W-1:0]          prod_ff;
   logic                              prod_valid_ff;
   logic                              prod_last_ff;
   logic signed [ACC_W-1:0]           acc_ff;
   logic signed [ACC_W-1:0]           rounded;
   logic signed [ACC_W-1:0]           shifted;
   logic signed [ACC_W-1:0]           sat;

   assign operand = ctl.use_x ? x_sample : hist_data;
   assign coef    = dfir_pkg::coef_at(ctl.tap);
   assign prod_in = operand * coef;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         prod_last_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= ctl.valid;
         prod_last_ff  <= ctl.valid & ctl.use_x;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (ctl.clear) begin
         acc_ff <= '0;
      end else if (prod_valid_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
   end

   assign done = prod_valid_ff & prod_last_ff;

   // round half up, then clamp
   always_comb begin
      rounded = acc_ff + ACC_W'(dfir_pkg::ROUND_BIAS);
      shifted = rounded >>> dfir_pkg::ROUND_SHIFT;
      if (shifted > SAT_HI) begin
         sat = SAT_HI;
      end else if (shifted < SAT_LO) begin
         sat = SAT_LO;
      end else begin
         sat = shifted;
      end
   end

   assign result = SAMPLE_BITS'(sat);

endmodule

/* hw/rtl/decimating_fir_resampler.sv */
// Decimating FIR resampler. One req_ transaction carries one sample; a rsp_
// transaction with the filtered value follows once TAPS samples have arrived
// since the last restart and the sample index minus TAPS-1 is a multiple of
// RATIO. For a sample that makes an output, the history sits in a memory with
// a write port and a read port, read one word per cycle into one shared
// multiplier via the read data, product and accumulator registers; round and
// saturate are combinational. No new sample is taken until its result is registered.
// Restart drops the history fill but keeps the decimation phase.
// depends on dfir_pkg and dfir_mac
module decimating_fir_resampler #(
   parameter int TAPS        = 31,
   parameter int RATIO       = 3,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          req_restart,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_filtered
);

   localparam int HIST_DEPTH   = TAPS - 1;
   localparam int ADDR_W       = $clog2(HIST_DEPTH);
   localparam int CNT_W        = $clog2(TAPS);
   localparam int PHASE_W      = $clog2(RATIO);
   localparam int PHASE_TARGET = HIST_DEPTH % RATIO;

   dfir_pkg::state_type state_ff, state_in;

   logic [SAMPLE_BITS-1:0]        hist_mem [HIST_DEPTH];
   logic [SAMPLE_BITS-1:0]        hist_rdata_ff;
   logic [ADDR_W-1:0]             wr_ptr_ff, wr_ptr_in;
   logic [ADDR_W-1:0]             rd_addr_ff, rd_addr_in;
   logic [CNT_W-1:0]              issue_cnt_ff, issue_cnt_in;
   logic [CNT_W-1:0]              fill_ff, fill_in, fill_eff;
   logic [PHASE_W-1:0]            phase_ff, phase_in;
   logic signed [SAMPLE_BITS-1:0] x_ff, x_in;
   logic                          rd_valid_ff, rd_is_x_ff;
   logic [CNT_W-1:0]              rd_idx_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_filtered_ff, rsp_filtered_in;

   logic                          accept;
   logic                          emit;
   logic                          issue_en;
   logic                          last_issue;
   logic                          out_fire;
   logic                          mem_we;
   logic [SAMPLE_BITS-1:0]        mem_wdata;
   logic                          mac_done;
   logic signed [SAMPLE_BITS-1:0] mac_result;
   dfir_pkg::mac_ctl_type         mac_ctl;

   assign fill_eff   = req_restart ? '0 : fill_ff;
   assign emit       = (fill_eff == CNT_W'(HIST_DEPTH)) && (phase_ff == PHASE_W'(PHASE_TARGET));
   assign last_issue = issue_cnt_ff == CNT_W'(HIST_DEPTH);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dfir_pkg::ST_IDLE: begin
            if (req_valid && emit) begin
               state_in = dfir_pkg::ST_MAC;
            end
         end
         dfir_pkg::ST_MAC: begin
            if (last_issue) begin
               state_in = dfir_pkg::ST_DRAIN;
            end
         end
         dfir_pkg::ST_DRAIN: begin
            if (mac_done) begin
               state_in = dfir_pkg::ST_OUT;
            end
         end
         dfir_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = dfir_pkg::ST_IDLE;
            end
         end
         default: state_in = dfir_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready = 1'b0;
      issue_en  = 1'b0;
      out_fire  = 1'b0;
      case (state_ff)
         dfir_pkg::ST_IDLE:  req_ready = 1'b1;
         dfir_pkg::ST_MAC:   issue_en  = 1'b1;
         dfir_pkg::ST_DRAIN: ;
         dfir_pkg::ST_OUT:   out_fire  = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   assign accept    = req_valid && req_ready;
   assign mem_we    = (accept && !emit) || out_fire;
   assign mem_wdata = out_fire ? x_ff : req_sample;

   always_comb begin
      fill_in      = fill_ff;
      phase_in     = phase_ff;
      x_in         = x_ff;
      wr_ptr_in    = wr_ptr_ff;
      rd_addr_in   = rd_addr_ff;
      issue_cnt_in = issue_cnt_ff;
      if (accept) begin
         fill_in      = (fill_eff == CNT_W'(HIST_DEPTH)) ? fill_eff : fill_eff + 1'b1;
         phase_in     = (phase_ff == PHASE_W'(RATIO - 1)) ? '0 : phase_ff + 1'b1;
         x_in         = req_sample;
         rd_addr_in   = wr_ptr_ff;
         issue_cnt_in = '0;
      end
      if (issue_en) begin
         issue_cnt_in = issue_cnt_ff + 1'b1;
         rd_addr_in   = (rd_addr_ff == ADDR_W'(HIST_DEPTH - 1)) ? '0 : rd_addr_ff + 1'b1;
      end
      if (mem_we) begin
         wr_ptr_in = (wr_ptr_ff == ADDR_W'(HIST_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      rsp_filtered_in = rsp_filtered_ff;
      if (out_fire) begin
         rsp_valid_in    = 1'b1;
         rsp_filtered_in = mac_result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dfir_pkg::ST_IDLE;
         fill_ff      <= '0;
         phase_ff     <= '0;
         wr_ptr_ff    <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         phase_ff     <= phase_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_valid_ff  <= issue_en;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff            <= x_in;
      rd_addr_ff      <= rd_addr_in;
      issue_cnt_ff    <= issue_cnt_in;
      rd_idx_ff       <= issue_cnt_ff;
      rd_is_x_ff      <= last_issue;
      rsp_filtered_ff <= rsp_filtered_in;
   end

   // history ring, oldest entry at the write pointer once full
   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist_mem[wr_ptr_ff] <= mem_wdata;
      end
      hist_rdata_ff <= hist_mem[rd_addr_ff];
   end

   assign mac_ctl.clear = accept && emit;
   assign mac_ctl.valid = rd_valid_ff;
   assign mac_ctl.use_x = rd_is_x_ff;
   assign mac_ctl.tap   = dfir_pkg::TAP_IDX_W'(rd_idx_ff);

   dfir_mac #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_mac (
      .clock     (clock),
      .reset     (reset),
      .ctl       (mac_ctl),
      .hist_data (hist_rdata_ff),
      .x_sample  (x_ff),
      .done      (mac_done),
      .result    (mac_result)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_filtered = rsp_filtered_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(HIST_DEPTH))
      else $error("fill count past history length");

   a_phase_bound: assert property (@(posedge clock) disable iff (reset)
      {1'b0, phase_ff} < (PHASE_W + 1)'(RATIO))
      else $error("phase count out of range");

   a_mac_needs_full: assert property (@(posedge clock) disable iff (reset)
      (accept && emit) |-> (fill_ff == CNT_W'(HIST_DEPTH) && !req_restart))
      else $error("mac started without full history");

   a_done_in_drain: assert property (@(posedge clock) disable iff (reset)
      mac_done |-> (state_ff == dfir_pkg::ST_DRAIN))
      else $error("mac finished outside drain");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_fire |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while held");

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// self-checking testbench for decimating_fir_resampler: directed stimulus table, then random samples
// carries its own decimating fir predictor; depends only on the rtl top level
module testbench;

   localparam int TAPS        = 31;
   localparam int RATIO       = 3;
   localparam int SAMPLE_BITS = 16;
   localparam int HIST_DEPTH  = TAPS - 1;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic signed [15:0] SMAX = 16'sh7FFF;
   localparam logic signed [15:0] SMIN = 16'sh8000;

   typedef enum logic [2:0] {
      SHAPE_FLAT,
      SHAPE_ALT,
      SHAPE_PEAK,
      SHAPE_TROUGH,
      SHAPE_NOISE
   } shape_type;

   typedef enum logic [1:0] {
      RESTART_NONE,
      RESTART_FIRST,
      RESTART_EVERY
   } restart_mode_type;

   typedef struct packed {
      shape_type          shape;
      logic signed [15:0] level;
      restart_mode_type   restart_mode;
      logic [7:0]         count;
      logic               typed;
      logic signed [15:0] want;
   } stim_row_type;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic signed [SAMPLE_BITS-1:0] req_sample;
   logic                          req_restart;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic signed [SAMPLE_BITS-1:0] rsp_filtered;

   int lowpass_coef [TAPS] = '{
      0,     232,   332,   0,     -761,  -1118, 0,     2217,
      3029,  0,     -5552, -7642, 0,     17310, 35691, 43596,
      35691, 17310, 0,     -7642, -5552, 0,     3029,  2217,
      0,     -1118, -761,  0,     332,   232,   0
   };

   // typed expectations hold for the single output that falls inside their row
   stim_row_type directed_rows [13] = '{
      '{SHAPE_FLAT,   16'sd0,     RESTART_NONE,  8'd31, 1'b1, 16'sd0},
      '{SHAPE_FLAT,   SMAX,       RESTART_FIRST, 8'd33, 1'b1, SMAX},
      '{SHAPE_FLAT,   SMIN,       RESTART_FIRST, 8'd33, 1'b1, SMIN},
      '{SHAPE_PEAK,   16'sd0,     RESTART_FIRST, 8'd33, 1'b1, SMAX},
      '{SHAPE_TROUGH, 16'sd0,     RESTART_FIRST, 8'd33, 1'b1, SMIN},
      '{SHAPE_FLAT,   16'sd1,     RESTART_FIRST, 8'd33, 1'b1, 16'sd1},
      '{SHAPE_FLAT,   -16'sd1,    RESTART_FIRST, 8'd33, 1'b1, -16'sd1},
      '{SHAPE_ALT,    16'sd20000, RESTART_NONE,  8'd12, 1'b0, 16'sd0},
      '{SHAPE_FLAT,   16'sd1000,  RESTART_FIRST, 8'd20, 1'b0, 16'sd0},
      '{SHAPE_NOISE,  16'sd0,     RESTART_EVERY, 8'd9,  1'b0, 16'sd0},
      '{SHAPE_NOISE,  16'sd0,     RESTART_FIRST, 8'd40, 1'b0, 16'sd0},
      '{SHAPE_NOISE,  16'sd0,     RESTART_NONE,  8'd24, 1'b0, 16'sd0},
      '{SHAPE_ALT,    SMAX,       RESTART_NONE,  8'd6,  1'b0, 16'sd0}
   };

   logic signed [15:0] tap_line [HIST_DEPTH];
   int                 fill_level;
   int                 phase_idx;
   logic signed [15:0] pending_filtered [$];
   int                 mismatch_count = 0;
   int                 gap_pct;
   int                 stall_pct;
   int                 stall_left = 0;

   decimating_fir_resampler #(
      .TAPS(TAPS),
      .RATIO(RATIO),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_sample(req_sample),
      .req_restart(req_restart),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_filtered(rsp_filtered)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic bit fir_decimate(input logic signed [15:0] x, input bit rs,
                                       output logic signed [15:0] y);
      longint acc;
      longint r;
      bit     fire;
      if (rs) begin
         for (int i = 0; i < HIST_DEPTH; i++) tap_line[i] = '0;
         fill_level = 0;
      end
      fire = (fill_level >= HIST_DEPTH) && (phase_idx == HIST_DEPTH % RATIO);
      y = '0;
      if (fire) begin
         acc = 0;
         for (int i = 0; i < HIST_DEPTH; i++) begin
            acc += longint'(lowpass_coef[i]) * longint'(tap_line[i]);
         end
         acc += longint'(lowpass_coef[HIST_DEPTH]) * longint'(x);
         r = (acc + 65536) >>> 17;
         if (r > 32767) r = 32767;
         if (r < -32768) r = -32768;
         y = r[15:0];
      end
      for (int i = 0; i < HIST_DEPTH - 1; i++) tap_line[i] = tap_line[i + 1];
      tap_line[HIST_DEPTH - 1] = x;
      if (fill_level < HIST_DEPTH) fill_level++;
      phase_idx = (phase_idx + 1) % RATIO;
      return fire;
   endfunction

   function automatic logic signed [15:0] noise_sample();
      logic signed [15:0] v;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0: v = SMAX;
               1: v = SMIN;
               2: v = 16'sd0;
               3: v = 16'sd1;
               default: v = -16'sd1;
            endcase
         end
         1, 2, 3: v = 16'($urandom_range(0, 511)) - 16'sd256;
         default: v = 16'($urandom);
      endcase
      return v;
   endfunction

   task automatic send_sample(input logic signed [15:0] s, input bit rs, input bit typed,
                              input logic signed [15:0] want);
      logic signed [15:0] y;
      int                 gap;
      if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
         gap = $urandom_range(1, 7);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_sample  <= s;
      req_restart <= rs;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (fir_decimate(s, rs, y)) pending_filtered.push_back(typed ? want : y);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_filtered.size() != 0);
   endtask

   task automatic flag_mismatch(input string what, input logic signed [15:0] want);
      if (mismatch_count < 10) begin
         $display("mismatch at %0t: %s, expected %0d, got %0d", $realtime, what, want,
                  rsp_filtered);
      end
      mismatch_count++;
   endtask

   // receiver side stall bursts
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
         stall_left = $urandom_range(1, 7) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_filtered
      logic signed [15:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_filtered.size() == 0) begin
            flag_mismatch("filtered transaction with none pending", 16'sd0);
         end else begin
            want = pending_filtered.pop_front();
            if (rsp_filtered !== want) flag_mismatch("filtered value", want);
         end
      end
   end

   initial begin : watchdog
      int cycles;
      for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clock);
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : stimulus
      stim_row_type       row;
      int                 offset;
      int                 idx;
      logic signed [15:0] s;
      bit                 rs;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_sample     = '0;
      req_restart    = 1'b0;
      fill_level     = 0;
      phase_idx      = 0;
      for (int i = 0; i < HIST_DEPTH; i++) tap_line[i] = '0;
      gap_pct   = 20;
      stall_pct = 20;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[r]) begin
         row = directed_rows[r];
         // first item of the row that lands on tap zero of the output window
         offset = (2 * RATIO + HIST_DEPTH % RATIO - (phase_idx + HIST_DEPTH) % RATIO) % RATIO;
         for (int k = 0; k < row.count; k++) begin
            idx = k - offset;
            rs  = (row.restart_mode == RESTART_EVERY) ||
                  (row.restart_mode == RESTART_FIRST && k == 0);
            case (row.shape)
               SHAPE_FLAT: s = row.level;
               SHAPE_ALT:  s = (k % 2 == 1) ? -row.level : row.level;
               SHAPE_PEAK, SHAPE_TROUGH: begin
                  if (idx < 0 || idx >= TAPS) s = '0;
                  else if ((lowpass_coef[idx] < 0) == (row.shape == SHAPE_PEAK)) s = SMIN;
                  else s = SMAX;
               end
               default: s = noise_sample();
            endcase
            send_sample(s, rs, row.typed, row.want);
         end
      end
      wait_for_drain();

      for (int seg = 0; seg < 10; seg++) begin
         if (seg == 9) begin
            gap_pct   = 0;
            stall_pct = 0;
         end else begin
            case ($urandom_range(0, 3))
               0: gap_pct = 0;
               1: gap_pct = 10;
               2: gap_pct = 35;
               default: gap_pct = 70;
            endcase
            case ($urandom_range(0, 3))
               0: stall_pct = 0;
               1: stall_pct = 10;
               2: stall_pct = 35;
               default: stall_pct = 70;
            endcase
         end
         for (int n = 0; n < 70; n++) begin
            send_sample(noise_sample(), $urandom_range(0, 99) < 2, 1'b0, 16'sd0);
         end
         if (seg == 4) wait_for_drain();
      end

      wait_for_drain();
      repeat (2 * TAPS + 8) @(posedge clock);
      if (mismatch_count == 0 && pending_filtered.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* decimating_fir_resampler.f */
hw/rtl/dfir_pkg.sv
hw/rtl/dfir_mac.sv
hw/rtl/decimating_fir_resampler.sv
verif/testbench.sv
